// ===== src/rpnse_pkg.sv =====
// Shared types and constants of the RPN stack arithmetic engine.
package rpnse_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   // Command actions.
   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_OPERATE = 2'd1;
   localparam logic [1:0] ACT_DROP    = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   // Operation codes.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_DIVZ  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_SAT   = 3'd4;

   // Saturation limits of the signed 64-bit word.
   localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

   // One command transaction.
   typedef struct packed {
      logic [1:0]        action;
      logic signed [63:0] value;
      logic [1:0]        op_code;
      logic [6:0]        repeat_count;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [63:0] top_value;
      logic [6:0]        stack_count;
      logic [2:0]        status;
   } rsp_type;

   // Result of the multiply/divide unit.
   typedef struct packed {
      logic        done;
      logic        sat;
      logic [63:0] value;
   } md_res_type;

endpackage

// ===== src/rpnse_muldiv.sv =====
// Multi-cycle fixed-point multiply and restoring divide unit with saturation.
module rpnse_muldiv import rpnse_pkg::*; #(
   parameter int FRAC_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_div,
   input  logic [63:0] y,
   input  logic [63:0] x,
   output md_res_type  res
);

   logic         busy_ff, div_ff, neg_ff, pv_ff;
   logic [7:0]   cnt_ff;
   logic [63:0]  a_ff, b_ff, pp_ff;
   logic [1:0]   pidx_ff;
   logic [127:0] num_ff, acc_ff;
   logic [64:0]  rem_ff;
   logic         done_ff, rsat_ff;
   logic [63:0]  rval_ff;

   logic [63:0]  mag_y, mag_x;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp_w;
   logic [127:0] pp_shift;
   logic [64:0]  rem_sh;
   logic         ge;
   logic         finish;
   logic [127:0] fin_mag;
   logic [64:0]  fin_sat;

   // Apply the sign to a 128-bit magnitude and saturate; bit 64 flags saturation.
   function automatic logic [64:0] sat_mag(input logic neg, input logic [127:0] m);
      logic [64:0] r;
      if (!neg) begin
         if (|m[127:63]) r = {1'b1, VAL_MAX};
         else            r = {1'b0, m[63:0]};
      end else begin
         if ((|m[127:64]) || (m[63] && (|m[62:0]))) r = {1'b1, VAL_MIN};
         else                                       r = {1'b0, 64'd0 - m[63:0]};
      end
      return r;
   endfunction

   // Operand magnitudes.
   assign mag_y = y[63] ? (64'd0 - y) : y;
   assign mag_x = x[63] ? (64'd0 - x) : x;

   // One 32x32 partial product per cycle.
   assign a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp_w   = a_half * b_half;

   always_comb begin
      unique case (pidx_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1,
         2'd2:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   // One quotient bit per cycle.
   assign rem_sh = {rem_ff[63:0], num_ff[127]};
   assign ge     = rem_sh >= {1'b0, b_ff};

   // Final scaling and saturation.
   assign finish  = busy_ff && (div_ff ? (cnt_ff == 8'd128) : (cnt_ff == 8'd5));
   assign fin_mag = div_ff ? acc_ff : (acc_ff >> FRAC_BITS);
   assign fin_sat = sat_mag(neg_ff, fin_mag);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish;
         if (start)       busy_ff <= 1'b1;
         else if (finish) busy_ff <= 1'b0;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= is_div;
         neg_ff <= y[63] ^ x[63];
         a_ff   <= mag_y;
         b_ff   <= mag_x;
         num_ff <= {64'd0, mag_y} << FRAC_BITS;
         rem_ff <= '0;
         acc_ff <= '0;
         cnt_ff <= '0;
         pv_ff  <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 8'd1;
         if (div_ff) begin
            if (cnt_ff != 8'd128) begin
               rem_ff <= ge ? (rem_sh - {1'b0, b_ff}) : rem_sh;
               acc_ff <= {acc_ff[126:0], ge};
               num_ff <= {num_ff[126:0], 1'b0};
            end
         end else begin
            pv_ff   <= cnt_ff < 8'd4;
            pp_ff   <= pp_w;
            pidx_ff <= cnt_ff[1:0];
            if (pv_ff) acc_ff <= acc_ff + pp_shift;
         end
      end
      if (finish) begin
         rsat_ff <= fin_sat[64];
         rval_ff <= fin_sat[63:0];
      end
   end

   assign res = {done_ff, rsat_ff, rval_ff};

endmodule

// ===== src/rpn_stack_arithmetic_engine_unit.sv =====
// Top level of the RPN stack arithmetic engine: command sequencer and stack memory.
//
// Commands arrive on the req_ channel (valid/stall); each produces exactly one
// result transaction on the rsp_ channel with the new top of stack, the entry
// count and a status. One command is processed at a time; req_stall is high
// while a command is in progress.
// Push, clear and drop go to the completion state; a drop leaving entries reloads top.
// Operate runs a loop over the stack memory, one pop-pop-push step at a time:
// add/subtract pass through the check and read states each step, multiply forms four
// 32x32 partial products in the multiply/divide unit, divide computes one quotient bit
// per cycle for 128 bits. A full reduction of N entries costs N-1 steps.
// The stack lives in a single memory with registered read; the top
// entry is also held in a register so a step needs one memory read.
// Reset empties the stack; memory contents are not cleared.
// A finished result waits in the output register while rsp_stall is high;
// a new command may already be accepted, and its result is held back until
// the output register has been emptied.
module rpn_stack_arithmetic_engine_unit import rpnse_pkg::*; #(
   parameter int FRAC_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_OPCHK  = 3'd1;
   localparam logic [2:0] S_OPRD   = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_DROPRD = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
   localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);

   logic [2:0]      state_ff, state_in;
   req_type         cmd_ff, cmd_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [63:0]     top_ff, top_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            sat_ff, sat_in;
   logic [2:0]      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [63:0]     mem [STACK_DEPTH];
   logic [63:0]     mem_q;
   logic            mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [63:0]     mem_wd;

   logic [SP_W-1:0] sp_m1, sp_m2;
   logic [63:0]     add_r, sub_r;
   logic            add_ovf, sub_ovf;
   logic            md_start;
   md_res_type      md_res;
   logic            out_free;
   logic [2:0]      fin_status;
   logic            req_fire;

   // Stack memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   // Multiply/divide unit; y comes from memory, x is the cached top.
   rpnse_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .is_div (cmd_ff.op_code == OP_DIV),
      .y      (mem_q),
      .x      (top_ff),
      .res    (md_res)
   );

   assign sp_m1 = sp_ff - SP_ONE;
   assign sp_m2 = sp_ff - SP_TWO;

   // Saturating add and subtract of y and x.
   assign add_r   = mem_q + top_ff;
   assign sub_r   = mem_q - top_ff;
   assign add_ovf = (mem_q[63] == top_ff[63]) && (add_r[63] != mem_q[63]);
   assign sub_ovf = (mem_q[63] != top_ff[63]) && (sub_r[63] != mem_q[63]);

   assign req_stall = state_ff != S_IDLE;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fin_status = ((cmd_ff.action == ACT_OPERATE) && sat_ff && (status_ff != ST_DIVZ))
                       ? ST_SAT : status_ff;

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wa       = sp_m2[ADDR_W-1:0];
      mem_wd       = top_ff;
      mem_ra       = sp_m2[ADDR_W-1:0];
      md_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data;
               status_in = ST_OK;
               sat_in    = 1'b0;
               state_in  = S_DONE;
               unique case (req_data.action)
                  ACT_PUSH: begin
                     if (sp_ff == SP_FULL) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = sp_ff[ADDR_W-1:0];
                        mem_wd = req_data.value;
                        top_in = req_data.value;
                        sp_in  = sp_ff + SP_ONE;
                     end
                  end
                  ACT_OPERATE: begin
                     if (req_data.repeat_count != 7'd0)
                        cnt_in = req_data.repeat_count;
                     else if (sp_ff != '0)
                        cnt_in = 7'(sp_m1);
                     else
                        cnt_in = 7'd0;
                     state_in = S_OPCHK;
                  end
                  ACT_DROP: begin
                     if (sp_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        sp_in = sp_m1;
                        if (sp_ff >= SP_TWO) state_in = S_DROPRD;
                     end
                  end
                  default: begin
                     sp_in = '0;
                  end
               endcase
            end
         end
         S_OPCHK: begin
            if ((cnt_ff == 7'd0) || (sp_ff < SP_TWO)) state_in = S_DONE;
            else                                      state_in = S_OPRD;
         end
         S_OPRD: begin
            unique case (cmd_ff.op_code)
               OP_ADD, OP_SUB: begin
                  mem_we   = 1'b1;
                  mem_wd   = (cmd_ff.op_code == OP_ADD)
                             ? (add_ovf ? (mem_q[63] ? VAL_MIN : VAL_MAX) : add_r)
                             : (sub_ovf ? (mem_q[63] ? VAL_MIN : VAL_MAX) : sub_r);
                  top_in   = mem_wd;
                  sat_in   = sat_ff || ((cmd_ff.op_code == OP_ADD) ? add_ovf : sub_ovf);
                  sp_in    = sp_m1;
                  cnt_in   = cnt_ff - 7'd1;
                  state_in = S_OPCHK;
               end
               OP_MUL: begin
                  md_start = 1'b1;
                  state_in = S_WAIT;
               end
               default: begin
                  if (top_ff == 64'd0) begin
                     status_in = ST_DIVZ;
                     state_in  = S_DONE;
                  end else begin
                     md_start = 1'b1;
                     state_in = S_WAIT;
                  end
               end
            endcase
         end
         S_WAIT: begin
            if (md_res.done) begin
               mem_we   = 1'b1;
               mem_wd   = md_res.value;
               top_in   = md_res.value;
               sat_in   = sat_ff || md_res.sat;
               sp_in    = sp_m1;
               cnt_in   = cnt_ff - 7'd1;
               state_in = S_OPCHK;
            end
         end
         S_DROPRD: begin
            top_in   = mem_q;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.top_value      = (sp_ff == '0) ? 64'd0 : top_ff;
               rsp_in.stack_count    = 7'(sp_ff);
               rsp_in.status         = fin_status;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      top_ff    <= top_in;
      cnt_ff    <= cnt_in;
      sat_ff    <= sat_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The entry count never passes the stack depth.
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_FULL)
      else $error("stack pointer beyond depth");

   // An accepted command always leaves the idle state.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("command accepted without leaving idle");

   // The arithmetic unit only reports completion while the sequencer waits.
   a_md_wait: assert property (@(posedge clock) disable iff (reset)
      md_res.done |-> state_ff == S_WAIT)
      else $error("arithmetic result outside wait state");

   // A new result comes only from the completion state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result produced outside completion");

endmodule
